>>> rtl/color_threshold_bounding_box_macros.svh
// ----------------------------------------------------------------------------
// Color threshold bounding box: assertion macros
// Shared concurrent assertion forms, clocked on clock and off during reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_THRESHOLD_BOUNDING_BOX_MACROS_SVH
`define COLOR_THRESHOLD_BOUNDING_BOX_MACROS_SVH

// same-cycle implication
`define CTBB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTBB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ctbb_pkg.sv
// ----------------------------------------------------------------------------
// Color threshold bounding box: package
// Register indexes, payload layouts and fixed field widths.
// ----------------------------------------------------------------------------
package ctbb_pkg;

   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int MIN_W     = 13;
   localparam int MAX_W     = 12;
   localparam int BOX_W     = 2 * MIN_W + 2 * MAX_W;
   localparam int RSP_W     = ((BOX_W + 7) / 8) * 8;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BLUE_LOW   = 3'd0,
      REG_BLUE_HIGH  = 3'd1,
      REG_GREEN_LOW  = 3'd2,
      REG_GREEN_HIGH = 3'd3,
      REG_RED_LOW    = 3'd4,
      REG_RED_HIGH   = 3'd5,
      REG_STEP_X     = 3'd6,
      REG_STEP_Y     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [MAX_W-1:0] max_y;
      logic [MAX_W-1:0] max_x;
      logic [MIN_W-1:0] min_y;
      logic [MIN_W-1:0] min_x;
   } box_type;

   typedef struct packed {
      logic [CH_W-1:0] blue_low;
      logic [CH_W-1:0] blue_high;
      logic [CH_W-1:0] green_low;
      logic [CH_W-1:0] green_high;
      logic [CH_W-1:0] red_low;
      logic [CH_W-1:0] red_high;
      logic [CH_W-1:0] step_x;
      logic [CH_W-1:0] step_y;
   } config_type;

   localparam config_type CONFIG_RESET = '{
      blue_low:   8'd0,
      blue_high:  8'd15,
      green_low:  8'd20,
      green_high: 8'd70,
      red_low:    8'd40,
      red_high:   8'd255,
      step_x:     8'd1,
      step_y:     8'd1
   };

endpackage

>>> rtl/color_threshold_bounding_box.sv
// ----------------------------------------------------------------------------
// Color threshold bounding box
// Samples a raster BGR pixel stream on a step grid, thresholds each channel
// and reports the bounding box of all hits once per frame.
//
//   channel  direction  payload
//   req_     in         tdata {red, green, blue}, tuser end_of_line,
//                       tlast end_of_frame
//   rsp_     out        tdata {max_y, max_x, min_y, min_x}, tuser found
//   csr_     in         csr_index register, csr_data value
//
// One pixel per cycle, except that an end-of-frame pixel waits for a free result.
// The input register feeds one compare and min/max stage into the result
// register. A stalled result holds only end-of-frame pixels; other pixels
// keep flowing. Reset restores the register defaults and clears the frame.
// ----------------------------------------------------------------------------
`include "color_threshold_bounding_box_macros.svh"

module color_threshold_bounding_box #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ctbb_pkg::PIX_W-1:0]          req_tdata,  // blue, green, red
   input  logic                                req_tuser,  // end_of_line
   input  logic                                req_tlast,  // end_of_frame
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ctbb_pkg::RSP_W-1:0]          rsp_tdata,  // min_x, min_y, max_x, max_y
   output logic                                rsp_tuser,  // found
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ctbb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ctbb_pkg::CH_W-1:0]           csr_data
);

   localparam int XW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LWW = $clog2(MAX_WIDTH + 1);
   localparam logic [XW-1:0] X_LAST = XW'(MAX_WIDTH - 1);
   localparam logic [YW-1:0] Y_LAST = YW'(MAX_HEIGHT - 1);

   ctbb_pkg::config_type cfg_ff, cfg_in;

   logic                   p1_valid_ff, p1_valid_in;
   ctbb_pkg::pixel_type    p1_pix_ff,   p1_pix_in;
   logic                   p1_eol_ff,   p1_eol_in;
   logic                   p1_eof_ff,   p1_eof_in;

   logic [XW-1:0]          col_ff,   col_in;
   logic [YW-1:0]          row_ff,   row_in;
   logic [7:0]             colph_ff, colph_in;
   logic [7:0]             rowph_ff, rowph_in;
   logic [LWW-1:0]         lw_ff,    lw_in;
   logic                   hit_ff,   hit_in;
   logic [XW-1:0]          lx_ff,    lx_in;
   logic [YW-1:0]          ly_ff,    ly_in;
   logic [XW-1:0]          mx_ff,    mx_in;
   logic [YW-1:0]          my_ff,    my_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   ctbb_pkg::box_type      rsp_box_ff,   rsp_box_in;
   logic                   rsp_found_ff, rsp_found_in;

   logic                   out_free;
   logic                   proc;
   logic                   pix_hit;
   logic [7:0]             step_x_eff, step_y_eff;
   logic [LWW-1:0]         cur_width;
   logic                   upd_hit;
   logic [XW-1:0]          upd_lx, upd_mx;
   logic [YW-1:0]          upd_ly, upd_my;
   logic [LWW-1:0]         upd_lw;
   logic [YW:0]            height;
   logic [8:0]             colph_inc, rowph_inc;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (ctbb_pkg::reg_index_type'(csr_index))
            ctbb_pkg::REG_BLUE_LOW:   cfg_in.blue_low   = csr_data;
            ctbb_pkg::REG_BLUE_HIGH:  cfg_in.blue_high  = csr_data;
            ctbb_pkg::REG_GREEN_LOW:  cfg_in.green_low  = csr_data;
            ctbb_pkg::REG_GREEN_HIGH: cfg_in.green_high = csr_data;
            ctbb_pkg::REG_RED_LOW:    cfg_in.red_low    = csr_data;
            ctbb_pkg::REG_RED_HIGH:   cfg_in.red_high   = csr_data;
            ctbb_pkg::REG_STEP_X:     cfg_in.step_x     = csr_data;
            ctbb_pkg::REG_STEP_Y:     cfg_in.step_y     = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // flow control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc       = p1_valid_ff && (!p1_eof_ff || out_free);
   assign req_tready = !p1_valid_ff || proc;

   always_comb begin
      p1_valid_in = p1_valid_ff;
      p1_pix_in   = p1_pix_ff;
      p1_eol_in   = p1_eol_ff;
      p1_eof_in   = p1_eof_ff;
      if (req_tready) begin
         p1_valid_in = req_tvalid;
         p1_pix_in   = ctbb_pkg::pixel_type'(req_tdata);
         p1_eol_in   = req_tuser;
         p1_eof_in   = req_tlast;
      end
   end

   // threshold and box update
   always_comb begin
      step_x_eff = (cfg_ff.step_x == 8'd0) ? 8'd1 : cfg_ff.step_x;
      step_y_eff = (cfg_ff.step_y == 8'd0) ? 8'd1 : cfg_ff.step_y;
      colph_inc  = {1'b0, colph_ff} + 9'd1;
      rowph_inc  = {1'b0, rowph_ff} + 9'd1;

      pix_hit = (colph_ff == 8'd0) && (rowph_ff == 8'd0)
             && (p1_pix_ff.blue  > cfg_ff.blue_low)  && (p1_pix_ff.blue  < cfg_ff.blue_high)
             && (p1_pix_ff.green > cfg_ff.green_low) && (p1_pix_ff.green < cfg_ff.green_high)
             && (p1_pix_ff.red   > cfg_ff.red_low)   && (p1_pix_ff.red   < cfg_ff.red_high);

      upd_hit = hit_ff || pix_hit;
      upd_lx  = (pix_hit && (col_ff < lx_ff)) ? col_ff : lx_ff;
      upd_ly  = (pix_hit && (row_ff < ly_ff)) ? row_ff : ly_ff;
      upd_mx  = (pix_hit && (col_ff > mx_ff)) ? col_ff : mx_ff;
      upd_my  = (pix_hit && (row_ff > my_ff)) ? row_ff : my_ff;

      cur_width = LWW'(col_ff) + LWW'(1);
      upd_lw    = (cur_width > lw_ff) ? cur_width : lw_ff;
      height    = {1'b0, row_ff} + {{YW{1'b0}}, 1'b1};

      col_in   = col_ff;
      row_in   = row_ff;
      colph_in = colph_ff;
      rowph_in = rowph_ff;
      lw_in    = lw_ff;
      hit_in   = hit_ff;
      lx_in    = lx_ff;
      ly_in    = ly_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;

      if (proc) begin
         if (p1_eof_ff) begin
            col_in   = '0;
            row_in   = '0;
            colph_in = '0;
            rowph_in = '0;
            lw_in    = '0;
            hit_in   = 1'b0;
            lx_in    = '1;
            ly_in    = '1;
            mx_in    = '0;
            my_in    = '0;
         end else begin
            lw_in  = upd_lw;
            hit_in = upd_hit;
            lx_in  = upd_lx;
            ly_in  = upd_ly;
            mx_in  = upd_mx;
            my_in  = upd_my;
            if (p1_eol_ff) begin
               col_in   = '0;
               colph_in = '0;
               row_in   = (row_ff < Y_LAST) ? row_ff + YW'(1) : row_ff;
               rowph_in = (rowph_inc >= {1'b0, step_y_eff}) ? 8'd0 : rowph_inc[7:0];
            end else begin
               col_in   = (col_ff < X_LAST) ? col_ff + XW'(1) : col_ff;
               colph_in = (colph_inc >= {1'b0, step_x_eff}) ? 8'd0 : colph_inc[7:0];
            end
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_box_in   = rsp_box_ff;
      rsp_found_in = rsp_found_ff;
      if (proc && p1_eof_ff) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = upd_hit;
         if (upd_hit) begin
            rsp_box_in.min_x = ctbb_pkg::MIN_W'(upd_lx);
            rsp_box_in.min_y = ctbb_pkg::MIN_W'(upd_ly);
            rsp_box_in.max_x = ctbb_pkg::MAX_W'(upd_mx);
            rsp_box_in.max_y = ctbb_pkg::MAX_W'(upd_my);
         end else begin
            rsp_box_in.min_x = ctbb_pkg::MIN_W'(upd_lw);
            rsp_box_in.min_y = ctbb_pkg::MIN_W'(height);
            rsp_box_in.max_x = '0;
            rsp_box_in.max_y = '0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= ctbb_pkg::CONFIG_RESET;
         p1_valid_ff  <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         colph_ff     <= '0;
         rowph_ff     <= '0;
         lw_ff        <= '0;
         hit_ff       <= 1'b0;
         lx_ff        <= '1;
         ly_ff        <= '1;
         mx_ff        <= '0;
         my_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         p1_valid_ff  <= p1_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         colph_ff     <= colph_in;
         rowph_ff     <= rowph_in;
         lw_ff        <= lw_in;
         hit_ff       <= hit_in;
         lx_ff        <= lx_in;
         ly_ff        <= ly_in;
         mx_ff        <= mx_in;
         my_ff        <= my_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_pix_ff    <= p1_pix_in;
      p1_eol_ff    <= p1_eol_in;
      p1_eof_ff    <= p1_eof_in;
      rsp_box_ff   <= rsp_box_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = ctbb_pkg::RSP_W'(rsp_box_ff);

   `CTBB_ASSERT_NOW(a_empty_box_zero_max, rsp_tvalid && !rsp_tuser, rsp_tdata[ctbb_pkg::BOX_W-1:2*ctbb_pkg::MIN_W] == '0, "empty frame result has nonzero max")
   `CTBB_ASSERT_NEXT(a_frame_clears, proc && p1_eof_ff, col_ff == '0 && row_ff == '0 && !hit_ff, "frame state not cleared after end of frame")
   `CTBB_ASSERT_NEXT(a_pixel_held, p1_valid_ff && !proc, p1_valid_ff && p1_eof_ff, "stalled pixel lost")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Color threshold bounding box testbench
// Streams BGR pixel frames into the block and checks each end-of-frame box
// against an in-bench tracker of hit positions and frame size. Directed
// frames cover the threshold edges, a missing end of line, a step change in
// mid-frame and zero steps. Random frames and noise follow under several
// sender and receiver idle mixes, plus one long receiver hold-off that backs
// up the input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned LONG_HOLD       = 600;
   localparam int unsigned ITEMS_PER_PHASE = 150;
   localparam int unsigned MAX_COORD       = 4095;

   typedef struct {
      logic [ctbb_pkg::CH_W-1:0] blue;
      logic [ctbb_pkg::CH_W-1:0] green;
      logic [ctbb_pkg::CH_W-1:0] red;
      logic                      eol;
      logic                      eof;
   } pixel_beat_type;

   typedef struct {
      logic              found;
      ctbb_pkg::box_type box;
   } frame_box_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ctbb_pkg::PIX_W-1:0]     req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ctbb_pkg::RSP_W-1:0]     rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [ctbb_pkg::CSR_IDX_W-1:0] csr_index  = ctbb_pkg::REG_BLUE_LOW;
   logic [ctbb_pkg::CH_W-1:0]      csr_data   = '0;

   pixel_beat_type pixel_queue[$];
   frame_box_type  box_queue[$];

   ctbb_pkg::config_type cfg_now;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned queued_items = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   int unsigned col_pos, row_pos, col_phase, row_phase, frame_width;
   int unsigned least_x, least_y, most_x, most_y;
   bit          seen_hit;

   color_threshold_bounding_box i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // blue, green, red
      .req_tuser  (req_tuser),   // end_of_line
      .req_tlast  (req_tlast),   // end_of_frame
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // min_x, min_y, max_x, max_y
      .rsp_tuser  (rsp_tuser),   // found
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void flag_error(string what, int unsigned want, int unsigned got);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR %s: expected %0d, got %0d", what, want, got);
      end
   endfunction

   function automatic void clear_frame();
      col_pos     = 0;
      row_pos     = 0;
      col_phase   = 0;
      row_phase   = 0;
      frame_width = 0;
      seen_hit    = 1'b0;
      least_x     = '1;
      least_y     = '1;
      most_x      = 0;
      most_y      = 0;
   endfunction

   function automatic bit in_window(logic [ctbb_pkg::CH_W-1:0] v,
                                    logic [ctbb_pkg::CH_W-1:0] lo,
                                    logic [ctbb_pkg::CH_W-1:0] hi);
      return v > lo && v < hi;
   endfunction

   function automatic int unsigned advance_phase(int unsigned phase,
                                                 logic [ctbb_pkg::CH_W-1:0] step);
      int unsigned s;
      s = (step == 0) ? 1 : step;
      return (phase + 1 >= s) ? 0 : phase + 1;
   endfunction

   function automatic void track_pixel(pixel_beat_type p);
      frame_box_type r;
      if (col_phase == 0 && row_phase == 0 &&
          in_window(p.blue, cfg_now.blue_low, cfg_now.blue_high) &&
          in_window(p.green, cfg_now.green_low, cfg_now.green_high) &&
          in_window(p.red, cfg_now.red_low, cfg_now.red_high)) begin
         seen_hit = 1'b1;
         if (col_pos < least_x) least_x = col_pos;
         if (row_pos < least_y) least_y = row_pos;
         if (col_pos > most_x) most_x = col_pos;
         if (row_pos > most_y) most_y = row_pos;
      end
      if (col_pos + 1 > frame_width) frame_width = col_pos + 1;
      if (p.eof) begin
         r.found     = seen_hit;
         r.box.min_x = ctbb_pkg::MIN_W'(seen_hit ? least_x : frame_width);
         r.box.min_y = ctbb_pkg::MIN_W'(seen_hit ? least_y : row_pos + 1);
         r.box.max_x = ctbb_pkg::MAX_W'(seen_hit ? most_x : 0);
         r.box.max_y = ctbb_pkg::MAX_W'(seen_hit ? most_y : 0);
         box_queue = {box_queue, r};
         clear_frame();
      end else if (p.eol) begin
         col_pos   = 0;
         col_phase = 0;
         if (row_pos < MAX_COORD) row_pos++;
         row_phase = advance_phase(row_phase, cfg_now.step_y);
      end else begin
         if (col_pos < MAX_COORD) col_pos++;
         col_phase = advance_phase(col_phase, cfg_now.step_x);
      end
   endfunction

   // pixel driver
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_pixel(pixel_queue.pop_front());
         end
         offer = (req_tvalid && !req_tready) ||
                 (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct);
         req_tvalid <= offer;
         if (offer) begin
            req_tdata <= {pixel_queue[0].red, pixel_queue[0].green, pixel_queue[0].blue};
            req_tuser <= pixel_queue[0].eol;
            req_tlast <= pixel_queue[0].eof;
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      frame_box_type     want;
      ctbb_pkg::box_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = ctbb_pkg::box_type'(rsp_tdata[ctbb_pkg::BOX_W-1:0]);
         if (box_queue.size() == 0) begin
            flag_error("result with no frame pending, found", 0, rsp_tuser);
         end else begin
            want = box_queue.pop_front();
            if (rsp_tuser !== want.found) flag_error("found", want.found, rsp_tuser);
            if (got.min_x !== want.box.min_x) flag_error("min_x", want.box.min_x, got.min_x);
            if (got.min_y !== want.box.min_y) flag_error("min_y", want.box.min_y, got.min_y);
            if (got.max_x !== want.box.max_x) flag_error("max_x", want.box.max_x, got.max_x);
            if (got.max_y !== want.box.max_y) flag_error("max_y", want.box.max_y, got.max_y);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void push_pixel(logic [ctbb_pkg::CH_W-1:0] b,
                                      logic [ctbb_pkg::CH_W-1:0] g,
                                      logic [ctbb_pkg::CH_W-1:0] r, logic eol, logic eof);
      pixel_beat_type p;
      p = '{blue: b, green: g, red: r, eol: eol, eof: eof};
      pixel_queue = {pixel_queue, p};
      queued_items++;
   endfunction

   function automatic logic [ctbb_pkg::CH_W-1:0] pick_channel(logic [ctbb_pkg::CH_W-1:0] lo,
                                                             logic [ctbb_pkg::CH_W-1:0] hi);
      if (hi > lo + 1 && $urandom_range(3) != 0) begin
         return ctbb_pkg::CH_W'($urandom_range(hi - 1, lo + 1));
      end
      return ctbb_pkg::CH_W'($urandom_range(255));
   endfunction

   function automatic void push_random_pixel(logic eol, logic eof);
      push_pixel(pick_channel(cfg_now.blue_low, cfg_now.blue_high),
                 pick_channel(cfg_now.green_low, cfg_now.green_high),
                 pick_channel(cfg_now.red_low, cfg_now.red_high), eol, eof);
   endfunction

   function automatic void queue_frame(int unsigned width, int unsigned height, bit ragged);
      int unsigned w;
      bit          last_col, last_row;
      for (int unsigned y = 0; y < height; y++) begin
         w = ragged ? $urandom_range(width, 1) : width;
         for (int unsigned x = 0; x < w; x++) begin
            last_col = (x == w - 1);
            last_row = (y == height - 1);
            push_random_pixel(last_col && !(last_row && $urandom_range(3) == 0),
                              last_col && last_row);
         end
      end
   endfunction

   function automatic void queue_noise(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         push_random_pixel($urandom_range(7) == 0, $urandom_range(15) == 0);
      end
   endfunction

   task automatic csr_write(ctbb_pkg::reg_index_type idx, logic [ctbb_pkg::CH_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ctbb_pkg::REG_BLUE_LOW:   cfg_now.blue_low   = value;
         ctbb_pkg::REG_BLUE_HIGH:  cfg_now.blue_high  = value;
         ctbb_pkg::REG_GREEN_LOW:  cfg_now.green_low  = value;
         ctbb_pkg::REG_GREEN_HIGH: cfg_now.green_high = value;
         ctbb_pkg::REG_RED_LOW:    cfg_now.red_low    = value;
         ctbb_pkg::REG_RED_HIGH:   cfg_now.red_high   = value;
         ctbb_pkg::REG_STEP_X:     cfg_now.step_x     = value;
         ctbb_pkg::REG_STEP_Y:     cfg_now.step_y     = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_tvalid || box_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_window(ctbb_pkg::reg_index_type lo_idx,
                               ctbb_pkg::reg_index_type hi_idx);
      logic [ctbb_pkg::CH_W-1:0] lo, hi;
      case ($urandom_range(9))
         0: begin lo = 8'd255; hi = ctbb_pkg::CH_W'($urandom_range(255)); end
         1: begin lo = ctbb_pkg::CH_W'($urandom_range(255)); hi = 8'd0; end
         2: begin lo = 8'd0; hi = 8'd255; end
         default: begin
            lo = ctbb_pkg::CH_W'($urandom_range(150));
            hi = ctbb_pkg::CH_W'($urandom_range(255, lo));
         end
      endcase
      csr_write(lo_idx, lo);
      csr_write(hi_idx, hi);
   endtask

   function automatic logic [ctbb_pkg::CH_W-1:0] pick_step();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2, 3, 4, 5: return 8'd1;
         default: return ctbb_pkg::CH_W'($urandom_range(4, 2));
      endcase
   endfunction

   task automatic randomize_config();
      write_window(ctbb_pkg::REG_BLUE_LOW, ctbb_pkg::REG_BLUE_HIGH);
      write_window(ctbb_pkg::REG_GREEN_LOW, ctbb_pkg::REG_GREEN_HIGH);
      write_window(ctbb_pkg::REG_RED_LOW, ctbb_pkg::REG_RED_HIGH);
      csr_write(ctbb_pkg::REG_STEP_X, pick_step());
      csr_write(ctbb_pkg::REG_STEP_Y, pick_step());
      @(negedge clock);
   endtask

   task automatic open_all_windows();
      csr_write(ctbb_pkg::REG_BLUE_LOW, 8'd0);
      csr_write(ctbb_pkg::REG_BLUE_HIGH, 8'd255);
      csr_write(ctbb_pkg::REG_GREEN_LOW, 8'd0);
      csr_write(ctbb_pkg::REG_GREEN_HIGH, 8'd255);
      csr_write(ctbb_pkg::REG_RED_LOW, 8'd0);
      csr_write(ctbb_pkg::REG_RED_HIGH, 8'd255);
   endtask

   initial begin
      int unsigned send_pcts[4];
      int unsigned stall_pcts[4];
      send_pcts  = '{0, 86, 0, 18};
      stall_pcts = '{0, 0, 86, 18};
      cfg_now = ctbb_pkg::CONFIG_RESET;
      clear_frame();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // threshold edges under reset settings
      push_pixel(8'd0, 8'd21, 8'd41, 1'b0, 1'b0);
      push_pixel(8'd1, 8'd21, 8'd41, 1'b0, 1'b0);
      push_pixel(8'd15, 8'd30, 8'd100, 1'b0, 1'b0);
      push_pixel(8'd14, 8'd69, 8'd254, 1'b0, 1'b0);
      push_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
      push_pixel(8'd8, 8'd20, 8'd100, 1'b0, 1'b0);
      push_pixel(8'd8, 8'd70, 8'd100, 1'b0, 1'b0);
      push_pixel(8'd8, 8'd45, 8'd40, 1'b0, 1'b0);
      push_pixel(8'd8, 8'd45, 8'd255, 1'b0, 1'b0);
      push_pixel(8'd7, 8'd50, 8'd200, 1'b1, 1'b1);
      // no hits, last row without end of line
      push_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
      push_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
      wait_idle();

      // step change in mid-frame
      open_all_windows();
      csr_write(ctbb_pkg::REG_STEP_X, 8'd3);
      csr_write(ctbb_pkg::REG_STEP_Y, 8'd255);
      @(negedge clock);
      push_pixel(8'd1, 8'd1, 8'd1, 1'b0, 1'b0);
      push_pixel(8'd1, 8'd1, 8'd1, 1'b0, 1'b0);
      wait_idle();
      csr_write(ctbb_pkg::REG_STEP_X, 8'd2);
      @(negedge clock);
      push_pixel(8'd1, 8'd1, 8'd1, 1'b0, 1'b0);
      push_pixel(8'd1, 8'd1, 8'd1, 1'b1, 1'b0);
      push_pixel(8'd1, 8'd1, 8'd1, 1'b0, 1'b1);
      wait_idle();

      // zero steps sample everything
      csr_write(ctbb_pkg::REG_STEP_X, 8'd0);
      csr_write(ctbb_pkg::REG_STEP_Y, 8'd0);
      @(negedge clock);
      push_pixel(8'd254, 8'd254, 8'd254, 1'b0, 1'b0);
      push_pixel(8'd254, 8'd254, 8'd254, 1'b1, 1'b0);
      push_pixel(8'd254, 8'd254, 8'd254, 1'b0, 1'b0);
      push_pixel(8'd254, 8'd254, 8'd254, 1'b1, 1'b1);
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         randomize_config();
         send_idle_pct  = send_pcts[ph];
         recv_stall_pct = stall_pcts[ph];
         queued_items   = 0;
         while (queued_items < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 15) queue_noise($urandom_range(20, 3));
            else queue_frame($urandom_range(8, 1), $urandom_range(5, 1), $urandom_range(3) == 0);
         end
         wait_idle();
      end

      // long receiver hold-off with a steady pixel stream
      randomize_config();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      for (int i = 0; i < 25; i++) queue_frame(2, 2, 1'b0);
      wait_idle();

      if (box_queue.size() != 0) flag_error("results outstanding", 0, box_queue.size());
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
